[rtl/rjns_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rjns_pkg;

	localparam int unsigned ID_WIDTH_DEF = 16;

	// results an item can give: two from join, one from notify, one from stabilize
	localparam int unsigned NSLOT = 4;
	localparam int unsigned SLOT_W = $clog2(NSLOT);

	localparam logic [7:0] CTL_NOTIFY = 8'd130;
	localparam logic [7:0] CTL_STAB   = 8'd132;

	localparam int unsigned CTL_JOIN_BIT = 0;
	localparam int unsigned CTL_NTFY_BIT = 1;
	localparam int unsigned CTL_STAB_BIT = 2;
	localparam int unsigned CTL_INT_BIT  = 7;

	localparam int unsigned CFG_W = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_IP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_PORT = 2'd2;

	typedef struct packed {
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
		logic [7:0]  ctl;
		logic [31:0] mip;
		logic [15:0] mport;
		logic [15:0] mid;
		logic        fault;
	} res_t;

	function automatic res_t mk_res(
		input logic [31:0] dip,
		input logic [15:0] dport,
		input logic [7:0]  ctl,
		input logic [31:0] mip,
		input logic [15:0] mport,
		input logic [15:0] mid
	);
		res_t r;
		r.dest_ip   = dip;
		r.dest_port = dport;
		r.ctl       = ctl;
		r.mip       = mip;
		r.mport     = mport;
		r.mid       = mid;
		r.fault     = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/ring_join_notify_stabilize_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Payload
// in       in_valid/in_ready    control, sender_id, sender_ip, sender_port
// out      out_valid/out_ready  dest_ip, dest_port, msg_control, msg_ip, msg_port,
//                               msg_id, fault, last
// cfg      wr_en (no wait)      wr_index, wr_data
//
// An item is registered, then decoded combinationally into zero to four results
// held in a result bundle; the bundle drains one result per cycle on the out
// channel while out_ready is high. A new item is taken every cycle while the
// bundle is free or drains its last result.
// arst_n clears ring entries, node registers and all valid flags.
// out_ready low holds the bundle and, once the input register fills, in_ready.

module ring_join_notify_stabilize_core
	import rjns_pkg::*;
#(
	parameter int unsigned ID_WIDTH = ID_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           control,
	input  wire logic [15:0]          sender_id,
	input  wire logic [31:0]          sender_ip,
	input  wire logic [15:0]          sender_port,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [31:0]               dest_ip,
	output logic [15:0]               dest_port,
	output logic [7:0]                msg_control,
	output logic [31:0]               msg_ip,
	output logic [15:0]               msg_port,
	output logic [15:0]               msg_id,
	output logic                      fault,
	output logic                      last
);

	logic [15:0] node_id_q;
	logic [31:0] node_ip_q;
	logic [15:0] node_port_q;

	logic                pred_valid_q, succ_valid_q;
	logic [ID_WIDTH-1:0] pred_ident_q, succ_ident_q;
	logic [31:0]         pred_addr_q, succ_addr_q;
	logic [15:0]         pred_portnum_q, succ_portnum_q;

	logic        valid_s1;
	logic [7:0]  ctl_s1;
	logic [15:0] sid_raw_s1;
	logic [31:0] sip_s1;
	logic [15:0] sport_s1;

	logic              valid_s2;
	res_t              res_s2 [NSLOT];
	logic [SLOT_W-1:0] last_s2;
	logic [SLOT_W-1:0] idx_q;

	logic out_done, adv;

	// next state and results for the item in the input register
	logic                pv_d, sv_d;
	logic [ID_WIDTH-1:0] pid_d, sid_d;
	logic [31:0]         paddr_d, saddr_d;
	logic [15:0]         pport_d, sport_d;
	res_t                res_d [NSLOT];
	logic [SLOT_W:0]     k;

	logic [ID_WIDTH-1:0] sid, me;
	logic [15:0]         sid16, me16;
	logic                fire, fault_hit, me_lt_p, s_gt_p, ins;

	assign out_done = valid_s2 && out_ready && (idx_q == last_s2);
	assign adv      = valid_s1 && (!valid_s2 || out_done);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q   <= '0;
			node_ip_q   <= '0;
			node_port_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_NODE_ID:   node_id_q   <= wr_data[15:0];
				CFG_NODE_IP:   node_ip_q   <= wr_data;
				CFG_NODE_PORT: node_port_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctl_s1     <= control;
			sid_raw_s1 <= sender_id;
			sip_s1     <= sender_ip;
			sport_s1   <= sender_port;
		end
	end

	always_comb begin
		sid   = ID_WIDTH'(sid_raw_s1);
		me    = ID_WIDTH'(node_id_q);
		sid16 = 16'(sid);
		me16  = 16'(me);
		fire  = ctl_s1[CTL_INT_BIT] &&
			(ctl_s1[CTL_JOIN_BIT] ^ ctl_s1[CTL_NTFY_BIT] ^ ctl_s1[CTL_STAB_BIT]);

		pv_d    = pred_valid_q;
		pid_d   = pred_ident_q;
		paddr_d = pred_addr_q;
		pport_d = pred_portnum_q;
		sv_d    = succ_valid_q;
		sid_d   = succ_ident_q;
		saddr_d = succ_addr_q;
		sport_d = succ_portnum_q;

		for (int i = 0; i < NSLOT; i++) begin
			res_d[i] = '0;
		end
		k         = '0;
		fault_hit = 1'b0;

		// an absent predecessor compares as -1, below every id
		me_lt_p = pred_valid_q && (me < pred_ident_q);
		s_gt_p  = !pred_valid_q || (sid > pred_ident_q);
		ins     = (sid > me) ? (me_lt_p && s_gt_p) : (s_gt_p || me_lt_p);

		if (fire && ctl_s1[CTL_JOIN_BIT]) begin
			if (!pred_valid_q && !succ_valid_q) begin
				pv_d = 1'b1; pid_d = sid; paddr_d = sip_s1; pport_d = sport_s1;
				sv_d = 1'b1; sid_d = sid; saddr_d = sip_s1; sport_d = sport_s1;
				res_d[k[SLOT_W-1:0]] = mk_res(sip_s1, sport_s1, CTL_NOTIFY,
					node_ip_q, node_port_q, me16);
				k = k + 1'b1;
				res_d[k[SLOT_W-1:0]] = mk_res(sip_s1, sport_s1, CTL_STAB,
					node_ip_q, node_port_q, me16);
				k = k + 1'b1;
			end else if (sid == me) begin
				fault_hit = 1'b1;
			end else if (ins) begin
				res_d[k[SLOT_W-1:0]] = mk_res(pred_addr_q, pred_portnum_q, CTL_NOTIFY,
					sip_s1, sport_s1, sid16);
				k = k + 1'b1;
				pv_d = 1'b1; pid_d = sid; paddr_d = sip_s1; pport_d = sport_s1;
				res_d[k[SLOT_W-1:0]] = mk_res(sip_s1, sport_s1, CTL_NOTIFY,
					node_ip_q, node_port_q, me16);
				k = k + 1'b1;
			end else begin
				res_d[k[SLOT_W-1:0]] = mk_res(succ_addr_q, succ_portnum_q, ctl_s1,
					sip_s1, sport_s1, sid16);
				k = k + 1'b1;
				res_d[k[SLOT_W-1:0]] = mk_res(succ_addr_q, succ_portnum_q, CTL_STAB,
					node_ip_q, node_port_q, me16);
				k = k + 1'b1;
			end
		end

		if (fire && !fault_hit && ctl_s1[CTL_NTFY_BIT]) begin
			if (!sv_d) begin
				sv_d = 1'b1; sid_d = sid; saddr_d = sip_s1; sport_d = sport_s1;
			end else if (sid != me) begin
				sid_d = sid; saddr_d = sip_s1; sport_d = sport_s1;
				res_d[k[SLOT_W-1:0]] = mk_res(sip_s1, sport_s1, CTL_STAB,
					node_ip_q, node_port_q, me16);
				k = k + 1'b1;
			end
		end

		if (fire && !fault_hit && ctl_s1[CTL_STAB_BIT]) begin
			if (!pv_d) begin
				pv_d = 1'b1; pid_d = sid; paddr_d = sip_s1; pport_d = sport_s1;
			end else begin
				res_d[k[SLOT_W-1:0]] = mk_res(sip_s1, sport_s1, CTL_NOTIFY,
					paddr_d, pport_d, 16'(pid_d));
				k = k + 1'b1;
			end
		end

		// own id on a non-empty ring: lone fault result, nothing else applies
		if (fault_hit) begin
			res_d[0]       = '0;
			res_d[0].fault = 1'b1;
			k              = (SLOT_W+1)'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_valid_q   <= 1'b0;
			pred_ident_q   <= '0;
			pred_addr_q    <= '0;
			pred_portnum_q <= '0;
			succ_valid_q   <= 1'b0;
			succ_ident_q   <= '0;
			succ_addr_q    <= '0;
			succ_portnum_q <= '0;
		end else if (adv) begin
			pred_valid_q   <= pv_d;
			pred_ident_q   <= pid_d;
			pred_addr_q    <= paddr_d;
			pred_portnum_q <= pport_d;
			succ_valid_q   <= sv_d;
			succ_ident_q   <= sid_d;
			succ_addr_q    <= saddr_d;
			succ_portnum_q <= sport_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (adv) begin
			valid_s2 <= (k != '0);
			idx_q    <= '0;
		end else if (out_done) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (valid_s2 && out_ready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2  <= res_d;
			last_s2 <= SLOT_W'(k - 1'b1);
		end
	end

	assign out_valid   = valid_s2;
	assign dest_ip     = res_s2[idx_q].dest_ip;
	assign dest_port   = res_s2[idx_q].dest_port;
	assign msg_control = res_s2[idx_q].ctl;
	assign msg_ip      = res_s2[idx_q].mip;
	assign msg_port    = res_s2[idx_q].mport;
	assign msg_id      = res_s2[idx_q].mid;
	assign fault       = res_s2[idx_q].fault;
	assign last        = (idx_q == last_s2);

`ifndef SYNTH
	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q <= last_s2))
		else $error("result index beyond bundle");

	a_fault_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault) |-> (last && idx_q == '0))
		else $error("fault result not alone");

	a_entries_stay: assert property (@(posedge clk) disable iff (!arst_n)
		(pred_valid_q && succ_valid_q) |=> (pred_valid_q && succ_valid_q))
		else $error("ring entry lost");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(pred_ident_q) && $stable(succ_ident_q)))
		else $error("ring state changed without an item");
`endif

endmodule

`default_nettype wire

[sim/ring_msg_checker.sv]
`timescale 1ns / 1ps

module ring_msg_checker
	import rjns_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,

	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic [7:0]           control,
	input  wire logic [15:0]          sender_id,
	input  wire logic [31:0]          sender_ip,
	input  wire logic [15:0]          sender_port,

	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic [31:0]          dest_ip,
	input  wire logic [15:0]          dest_port,
	input  wire logic [7:0]           msg_control,
	input  wire logic [31:0]          msg_ip,
	input  wire logic [15:0]          msg_port,
	input  wire logic [15:0]          msg_id,
	input  wire logic                 fault,
	input  wire logic                 last,

	output int                        mismatches,
	output int                        outstanding
);

	typedef struct packed {
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
		logic [7:0]  ctl;
		logic [31:0] mip;
		logic [15:0] mport;
		logic [15:0] mid;
		logic        fault;
		logic        last;
	} ring_msg_t;

	ring_msg_t due_msgs[$];

	// node registers
	logic [15:0] my_id;
	logic [31:0] my_ip;
	logic [15:0] my_port;

	// ring neighbours
	logic        pred_on, succ_on;
	logic [15:0] pred_id, succ_id;
	logic [31:0] pred_ip, succ_ip;
	logic [15:0] pred_port, succ_port;

	function automatic ring_msg_t ring_msg(
		input logic [31:0] dip,
		input logic [15:0] dport,
		input logic [7:0]  ctl,
		input logic [31:0] mip,
		input logic [15:0] mport,
		input logic [15:0] mid
	);
		ring_msg_t m;
		m = '0;
		m.dest_ip = dip;
		m.dest_port = dport;
		m.ctl = ctl;
		m.mip = mip;
		m.mport = mport;
		m.mid = mid;
		return m;
	endfunction

	task automatic set_pred(input logic [15:0] sid, input logic [31:0] sip,
			input logic [15:0] sport);
		pred_on = 1'b1;
		pred_id = sid;
		pred_ip = sip;
		pred_port = sport;
	endtask

	task automatic set_succ(input logic [15:0] sid, input logic [31:0] sip,
			input logic [15:0] sport);
		succ_on = 1'b1;
		succ_id = sid;
		succ_ip = sip;
		succ_port = sport;
	endtask

	// join, then notify, then stabilize; pushes the outgoing messages of one item
	task automatic predict_control(input logic [7:0] ctl, input logic [15:0] sid,
			input logic [31:0] sip, input logic [15:0] sport);
		ring_msg_t batch[4];
		ring_msg_t m;
		int k;
		logic j, n, s, ins;
		int pid, sv, mv;
		k = 0;
		j = ctl[CTL_JOIN_BIT];
		n = ctl[CTL_NTFY_BIT];
		s = ctl[CTL_STAB_BIT];
		if (!ctl[CTL_INT_BIT] || !(j ^ n ^ s))
			return;
		if (j) begin
			// an absent predecessor sits below every id
			pid = pred_on ? int'(pred_id) : -1;
			sv = int'(sid);
			mv = int'(my_id);
			if (!pred_on && !succ_on) begin
				set_succ(sid, sip, sport);
				set_pred(sid, sip, sport);
				batch[k++] = ring_msg(sip, sport, CTL_NOTIFY, my_ip, my_port, my_id);
				batch[k++] = ring_msg(succ_ip, succ_port, CTL_STAB, my_ip, my_port, my_id);
			end else if (sv == mv) begin
				m = '0;
				m.fault = 1'b1;
				m.last = 1'b1;
				due_msgs.push_back(m);
				return;
			end else begin
				if (sv > mv)
					ins = (mv < pid) && (sv > pid);
				else
					ins = (sv > pid) || (mv < pid);
				if (ins) begin
					batch[k++] = ring_msg(pred_ip, pred_port, CTL_NOTIFY, sip, sport, sid);
					set_pred(sid, sip, sport);
					batch[k++] = ring_msg(sip, sport, CTL_NOTIFY, my_ip, my_port, my_id);
				end else begin
					batch[k++] = ring_msg(succ_ip, succ_port, ctl, sip, sport, sid);
					batch[k++] = ring_msg(succ_ip, succ_port, CTL_STAB, my_ip, my_port, my_id);
				end
			end
		end
		if (n) begin
			if (!succ_on) begin
				set_succ(sid, sip, sport);
			end else if (sid != my_id) begin
				set_succ(sid, sip, sport);
				batch[k++] = ring_msg(sip, sport, CTL_STAB, my_ip, my_port, my_id);
			end
		end
		if (s) begin
			if (!pred_on)
				set_pred(sid, sip, sport);
			else
				batch[k++] = ring_msg(sip, sport, CTL_NOTIFY, pred_ip, pred_port, pred_id);
		end
		for (int i = 0; i < k; i++) begin
			m = batch[i];
			m.last = (i == k - 1);
			due_msgs.push_back(m);
		end
	endtask

	task automatic check_result();
		ring_msg_t got, want;
		got.dest_ip = dest_ip;
		got.dest_port = dest_port;
		got.ctl = msg_control;
		got.mip = msg_ip;
		got.mport = msg_port;
		got.mid = msg_id;
		got.fault = fault;
		got.last = last;
		if (due_msgs.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected item dest=%h:%h ctl=%h msg=%h:%h id=%h fault=%b last=%b",
					$realtime, got.dest_ip, got.dest_port, got.ctl, got.mip, got.mport,
					got.mid, got.fault, got.last);
		end else begin
			want = due_msgs.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: item mismatch", $realtime);
					$display("  expected dest=%h:%h ctl=%h msg=%h:%h id=%h fault=%b last=%b",
						want.dest_ip, want.dest_port, want.ctl, want.mip, want.mport,
						want.mid, want.fault, want.last);
					$display("  actual   dest=%h:%h ctl=%h msg=%h:%h id=%h fault=%b last=%b",
						got.dest_ip, got.dest_port, got.ctl, got.mip, got.mport,
						got.mid, got.fault, got.last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_id = '0;
			my_ip = '0;
			my_port = '0;
			pred_on = 1'b0;
			pred_id = '0;
			pred_ip = '0;
			pred_port = '0;
			succ_on = 1'b0;
			succ_id = '0;
			succ_ip = '0;
			succ_port = '0;
			due_msgs.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					CFG_NODE_ID:   my_id = wr_data[15:0];
					CFG_NODE_IP:   my_ip = wr_data[31:0];
					CFG_NODE_PORT: my_port = wr_data[15:0];
					default: ;
				endcase
			end
			// results at this edge belong to items taken earlier
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				predict_control(control, sender_id, sender_ip, sender_port);
			outstanding = due_msgs.size();
		end
	end

endmodule

[sim/ring_join_notify_stabilize_core_tb.sv]
`timescale 1ns / 1ps

module ring_join_notify_stabilize_core_tb;
	import rjns_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_ITEMS = 62;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           control;
	logic [15:0]          sender_id;
	logic [31:0]          sender_ip;
	logic [15:0]          sender_port;
	logic                 out_valid;
	logic                 out_ready;
	logic [31:0]          dest_ip;
	logic [15:0]          dest_port;
	logic [7:0]           msg_control;
	logic [31:0]          msg_ip;
	logic [15:0]          msg_port;
	logic [15:0]          msg_id;
	logic                 fault;
	logic                 last;

	int          fail_count;
	int          queued;
	int          idle_cycles = 0;
	int          hold = 0;
	bit          calm = 1'b0;
	logic [15:0] cur_id = '0;

	ring_join_notify_stabilize_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.control(control),
		.sender_id(sender_id),
		.sender_ip(sender_ip),
		.sender_port(sender_port),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dest_ip(dest_ip),
		.dest_port(dest_port),
		.msg_control(msg_control),
		.msg_ip(msg_ip),
		.msg_port(msg_port),
		.msg_id(msg_id),
		.fault(fault),
		.last(last)
	);

	ring_msg_checker monitor (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.control(control),
		.sender_id(sender_id),
		.sender_ip(sender_ip),
		.sender_port(sender_port),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dest_ip(dest_ip),
		.dest_port(dest_port),
		.msg_control(msg_control),
		.msg_ip(msg_ip),
		.msg_port(msg_port),
		.msg_id(msg_id),
		.fault(fault),
		.last(last),
		.mismatches(fail_count),
		.outstanding(queued)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// mostly short gaps, the odd long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					hold = pick_gap();
			end
		end
	end

	function automatic logic [7:0] pick_control();
		int r;
		logic [7:0] ctl;
		r = $urandom_range(0, 99);
		if (r < 12)
			return 8'($urandom_range(0, 255));
		ctl = '0;
		ctl[CTL_INT_BIT] = 1'b1;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			ctl[CTL_JOIN_BIT] = 1'b1;
		end else if (r < 65) begin
			ctl[CTL_NTFY_BIT] = 1'b1;
		end else if (r < 90) begin
			ctl[CTL_STAB_BIT] = 1'b1;
		end else begin
			ctl[CTL_JOIN_BIT] = 1'b1;
			ctl[CTL_NTFY_BIT] = 1'b1;
			ctl[CTL_STAB_BIT] = 1'b1;
		end
		// spare bits ride along in forwarded joins
		if ($urandom_range(0, 3) == 0)
			ctl[6:3] = 4'($urandom_range(0, 15));
		return ctl;
	endfunction

	// ids cluster around our own so that faults and own-id notifies turn up
	function automatic logic [15:0] pick_id();
		int r;
		logic [15:0] v;
		r = $urandom_range(0, 99);
		v = cur_id;
		if (r < 20)
			return v;
		if (r < 25)
			return 16'h0000;
		if (r < 30)
			return 16'hFFFF;
		if (r < 50) begin
			v = v + 16'($urandom_range(0, 16)) - 16'd8;
			return v;
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic send_msg(input logic [7:0] ctl, input logic [15:0] sid,
			input logic [31:0] sip, input logic [15:0] sport);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		control <= ctl;
		sender_id <= sid;
		sender_ip <= sip;
		sender_port <= sport;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// ignored items leave nothing queued, so allow the pipeline time to empty
	task automatic settle_ring();
		in_valid <= 1'b0;
		while (queued != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_node(input logic [15:0] id, input logic [31:0] ip,
			input logic [15:0] port);
		logic [15:0] junk;
		junk = 16'($urandom_range(0, 65535));
		cur_id = id;
		wr_en <= 1'b1;
		wr_index <= CFG_NODE_ID;
		wr_data <= {junk, id};
		@(negedge clk);
		wr_index <= CFG_NODE_IP;
		wr_data <= ip;
		@(negedge clk);
		wr_index <= CFG_NODE_PORT;
		wr_data <= {~junk, port};
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		logic [7:0] ctl;
		int live;
		bit paused;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		control = '0;
		sender_id = '0;
		sender_ip = '0;
		sender_port = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty ring, first join carries our own id
		write_node(16'h8000, $urandom, 16'($urandom_range(0, 65535)));
		send_msg(8'h01, 16'h8000, $urandom, 16'h1111);
		send_msg(8'h83, 16'h1234, $urandom, 16'h2222);
		send_msg(8'h80, 16'h1234, $urandom, 16'h3333);
		send_msg(8'h81, 16'h8000, 32'h0a00_0001, 16'h0101);
		send_msg(8'h81, 16'h8000, $urandom, 16'h0202);
		send_msg(8'h87, 16'h8000, $urandom, 16'h0303);
		send_msg(8'h81, 16'h0000, 32'h0000_0000, 16'h0000);
		send_msg(8'h82, 16'h8000, $urandom, 16'h0404);
		send_msg(8'h82, 16'hC000, $urandom, 16'h0505);
		send_msg(8'h84, 16'h4000, $urandom, 16'h0606);

		// predecessor now below us: insertion from below, all flags at once
		settle_ring();
		write_node(16'h9000, 32'hFFFF_FFFF, 16'hFFFF);
		send_msg(8'h81, 16'h8800, $urandom, 16'h0707);
		send_msg(8'hFF, 16'hA000, $urandom, 16'h0808);
		send_msg(8'h81, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);

		// predecessor above us: both wrap-around insertions, then a fault
		settle_ring();
		write_node(16'h4000, 32'h0000_0000, 16'h0000);
		send_msg(8'h81, 16'hFFFF, $urandom, 16'h0909);
		send_msg(8'h81, 16'h1000, $urandom, 16'h0a0a);
		send_msg(8'h81, 16'h4000, $urandom, 16'h0b0b);
		send_msg(8'h7F, 16'h2000, $urandom, 16'h0c0c);

		paused = 1'b0;
		for (int ph = 0; ph < 6; ph++) begin
			settle_ring();
			case (ph)
				0: write_node(16'hFFFF, 32'h0000_0000, 16'h0000);
				2: write_node(16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
				default: write_node(16'($urandom_range(0, 65535)), $urandom,
					16'($urandom_range(0, 65535)));
			endcase
			calm = (ph == 1);
			live = 0;
			while (live < PHASE_ITEMS) begin
				ctl = pick_control();
				send_msg(ctl, pick_id(), $urandom, 16'($urandom_range(0, 65535)));
				if (ctl[CTL_INT_BIT] && (ctl[CTL_JOIN_BIT] ^ ctl[CTL_NTFY_BIT] ^ ctl[CTL_STAB_BIT]))
					live++;
				if (ph == 3 && !paused && live == PHASE_ITEMS / 2) begin
					paused = 1'b1;
					settle_ring();
				end
			end
		end
		calm = 1'b0;

		settle_ring();
		if (fail_count == 0 && queued == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
rtl/rjns_pkg.sv
rtl/ring_join_notify_stabilize_core.sv
sim/ring_msg_checker.sv
sim/ring_join_notify_stabilize_core_tb.sv
